// File: rtl/emc_pkg.sv
// Shared types and constants for the ElGamal modular exponentiation cipher.
package emc_pkg;

  localparam int FIELD_W       = 16;
  localparam int MOD_WIDTH_DEF = 16;
  localparam int CFG_IDX_W     = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PUBLIC    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIVATE   = 2'd3;

  // Configuration reset values
  localparam logic [FIELD_W-1:0] MODULUS_RST   = 16'd883;
  localparam logic [FIELD_W-1:0] GENERATOR_RST = 16'd39;
  localparam logic [FIELD_W-1:0] PUBLIC_RST    = 16'd1;
  localparam logic [FIELD_W-1:0] PRIVATE_RST   = 16'd0;

  // Request opcodes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Modular multiply micro-operations
  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_RED1,
    MOP_RED2,
    MOP_SQ,
    MOP_MUL,
    MOP_FIN
  } emc_mop_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RED1_GO,
    S_RED1,
    S_RED2_GO,
    S_RED2,
    S_INIT,
    S_SQ_GO,
    S_SQ,
    S_MUL_GO,
    S_MUL,
    S_NEXT,
    S_FIN_GO,
    S_FIN,
    S_DONE
  } emc_state_e;

  typedef struct packed {
    logic     load;
    logic     go;
    logic     exp_init;
    logic     bit_next;
    emc_mop_e mop;
  } emc_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_bit;
    logic last_bit;
    logic p_zero;
  } emc_status_t;

endpackage

// File: rtl/elgamal_modexp_cipher.sv
// Top level of the ElGamal modular exponentiation cipher.
//
// ElGamal encrypt/decrypt over a prime field of up to MOD_WIDTH bits. A request is
// taken when start is high and busy is low; busy stays high until the result has been
// shown. The result is on cipher_first_o, value_out_o and operand_error_o for exactly
// one cycle with done_o high, and the receiver cannot hold it off, so capture it then.
// Encrypt (op 0) gives a = g^k mod p and b = y^k * m mod p; decrypt (op 1) gives
// m = a^(p-1-x) * b mod p with cipher_first_o at zero. Data operands not below the
// modulus are reduced and flagged on operand_error_o; a zero modulus gives zero outputs
// with the flag set. One request at a time. Every modular product runs on a bit-serial
// shift-and-add multiplier at one multiplier bit per cycle over W = MOD_WIDTH bits;
// the exponent is scanned over all W bits, one square per bit and one extra multiply
// per set bit (encrypt runs both powers in two lanes side by side).
// After the result strobe the block returns to idle before it takes the next request;
// a zero modulus goes from the check straight to the strobe. Config registers (index 0
// modulus, 1 generator, 2 public key, 3 private key) are written with cfg_we_i and must
// only change while busy is low.
module elgamal_modexp_cipher #(
  parameter int MOD_WIDTH = emc_pkg::MOD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [emc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [emc_pkg::FIELD_W-1:0]   cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [emc_pkg::FIELD_W-1:0]   first_operand_i,
  input  logic [emc_pkg::FIELD_W-1:0]   second_operand_i,
  input  logic [emc_pkg::FIELD_W-1:0]   session_key_i,
  output logic                          done_o,
  output logic [emc_pkg::FIELD_W-1:0]   cipher_first_o,
  output logic [emc_pkg::FIELD_W-1:0]   value_out_o,
  output logic                          operand_error_o
);
  import emc_pkg::*;

  emc_cmd_t    cmd;
  emc_status_t sts;

  // Sequencer: reduce operands, scan exponent, final product, result strobe
  emc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Config registers, operand registers and the two multiplier lanes
  emc_datapath #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (op_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .session_key_i    (session_key_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cipher_first_o   (cipher_first_o),
    .value_out_o      (value_out_o),
    .operand_error_o  (operand_error_o)
  );

endmodule

// File: rtl/emc_mulmod.sv
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
module emc_mulmod #(
  parameter int MOD_WIDTH = emc_pkg::MOD_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  logic [MOD_WIDTH-1:0] u_i,
  input  logic [MOD_WIDTH-1:0] v_i,
  input  logic [MOD_WIDTH-1:0] n_i,
  output logic                 done_o,
  output logic [MOD_WIDTH-1:0] res_o
);
  import emc_pkg::*;

  localparam int W  = MOD_WIDTH;
  localparam int CW = $clog2(W);

  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  u_q, v_q, n_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;

  logic [W:0] n_ext, dbl, d1, sum, d2;

  always_comb begin
    n_ext = {1'b0, n_q};
    dbl   = {acc_q, 1'b0};
    d1    = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
    sum   = {1'b0, d1[W-1:0]} + {1'b0, u_q};
    d2    = (sum >= n_ext) ? (sum - n_ext) : sum;
    acc_d = v_q[W-1] ? d2[W-1:0] : d1[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(W - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      acc_q <= '0;
      u_q   <= u_i;
      v_q   <= v_i;
      n_q   <= n_i;
    end else if (run_q) begin
      acc_q <= acc_d;
      v_q   <= {v_q[W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

// File: rtl/emc_datapath.sv
// Datapath: config registers, operand and accumulator registers, two multiplier lanes.
module emc_datapath #(
  parameter int MOD_WIDTH = emc_pkg::MOD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [emc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [emc_pkg::FIELD_W-1:0]       cfg_wdata_i,
  input  logic                              op_i,
  input  logic [emc_pkg::FIELD_W-1:0]       first_operand_i,
  input  logic [emc_pkg::FIELD_W-1:0]       second_operand_i,
  input  logic [emc_pkg::FIELD_W-1:0]       session_key_i,
  input  emc_pkg::emc_cmd_t                 cmd_i,
  output emc_pkg::emc_status_t              sts_o,
  output logic [emc_pkg::FIELD_W-1:0]       cipher_first_o,
  output logic [emc_pkg::FIELD_W-1:0]       value_out_o,
  output logic                              operand_error_o
);
  import emc_pkg::*;

  localparam int W  = MOD_WIDTH;
  localparam int CW = $clog2(W);

  logic [FIELD_W-1:0] modulus_q, generator_q, public_q, private_q;

  logic [W-1:0] p_w, pm1_w, one_w, gen_w, pub_w, priv_w;
  logic [W-1:0] first_w, second_w;

  logic          op_q, err_q;
  logic [W-1:0]  opa_q, opb_q;
  logic [W-1:0]  base_a_q, base_b_q, m_q;
  logic [W-1:0]  acc_a_q, acc_b_q;
  logic [W-1:0]  exp_q;
  logic [CW-1:0] bit_cnt_q;
  logic [W-1:0]  c1_q, val_q;

  logic [W-1:0] ua, va, na, ub, vb, nb;
  logic [W-1:0] res_a, res_b;
  logic         done_a, done_b;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= MODULUS_RST;
      generator_q <= GENERATOR_RST;
      public_q    <= PUBLIC_RST;
      private_q   <= PRIVATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODULUS:   modulus_q   <= cfg_wdata_i;
        REG_GENERATOR: generator_q <= cfg_wdata_i;
        REG_PUBLIC:    public_q    <= cfg_wdata_i;
        REG_PRIVATE:   private_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign p_w      = W'(modulus_q);
  assign gen_w    = W'(generator_q);
  assign pub_w    = W'(public_q);
  assign priv_w   = W'(private_q);
  assign first_w  = W'(first_operand_i);
  assign second_w = W'(second_operand_i);
  assign pm1_w    = p_w - 1'b1;
  // 1 mod p: zero for a modulus of one
  assign one_w    = {{(W-1){1'b0}}, (p_w != W'(1))};

  // Lane operand selection, sampled by the lanes on go
  always_comb begin
    ua = one_w;
    va = '0;
    na = p_w;
    ub = one_w;
    vb = '0;
    nb = p_w;
    case (cmd_i.mop)
      MOP_RED1: begin
        va = (op_q == OP_DECRYPT) ? opa_q : gen_w;
        vb = (op_q == OP_DECRYPT) ? opb_q : pub_w;
      end
      MOP_RED2: begin
        va = (op_q == OP_DECRYPT) ? priv_w : opb_q;
        na = (op_q == OP_DECRYPT) ? pm1_w : p_w;
      end
      MOP_SQ: begin
        ua = acc_a_q;
        va = acc_a_q;
        ub = acc_b_q;
        vb = acc_b_q;
      end
      MOP_MUL: begin
        ua = acc_a_q;
        va = base_a_q;
        ub = acc_b_q;
        vb = base_b_q;
      end
      MOP_FIN: begin
        ua = (op_q == OP_DECRYPT) ? acc_a_q : acc_b_q;
        va = m_q;
      end
      default: ;
    endcase
  end

  emc_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_lane_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.go),
    .u_i    (ua),
    .v_i    (va),
    .n_i    (na),
    .done_o (done_a),
    .res_o  (res_a)
  );

  emc_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_lane_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.go),
    .u_i    (ub),
    .v_i    (vb),
    .n_i    (nb),
    .done_o (done_b),
    .res_o  (res_b)
  );

  // Operand, accumulator and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      opa_q <= first_w;
      opb_q <= second_w;
      exp_q <= W'(session_key_i);
      c1_q  <= '0;
      val_q <= '0;
      if (p_w == '0) begin
        err_q <= 1'b1;
      end else if (op_i == OP_DECRYPT) begin
        err_q <= (first_w >= p_w) || (second_w >= p_w);
      end else begin
        err_q <= (second_w >= p_w);
      end
    end

    if (cmd_i.exp_init) begin
      acc_a_q   <= one_w;
      acc_b_q   <= one_w;
      bit_cnt_q <= CW'(W - 1);
      if (op_q == OP_DECRYPT) begin
        // exp_q holds x mod (p-1) here
        exp_q <= (pm1_w == '0) ? '0 : (pm1_w - exp_q);
      end
    end else if (cmd_i.bit_next) begin
      exp_q     <= {exp_q[W-2:0], 1'b0};
      bit_cnt_q <= bit_cnt_q - 1'b1;
    end

    if (done_a) begin
      case (cmd_i.mop)
        MOP_RED1: begin
          base_a_q <= res_a;
          if (op_q == OP_DECRYPT) begin
            m_q <= res_b;
          end else begin
            base_b_q <= res_b;
          end
        end
        MOP_RED2: begin
          if (op_q == OP_DECRYPT) begin
            exp_q <= res_a;
          end else begin
            m_q <= res_a;
          end
        end
        MOP_SQ, MOP_MUL: begin
          acc_a_q <= res_a;
          acc_b_q <= res_b;
        end
        MOP_FIN: begin
          val_q <= res_a;
          c1_q  <= (op_q == OP_DECRYPT) ? '0 : acc_a_q;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts_o.mul_done = done_a & done_b;
    sts_o.exp_bit  = exp_q[W-1];
    sts_o.last_bit = (bit_cnt_q == '0);
    sts_o.p_zero   = (p_w == '0);
  end

  assign cipher_first_o  = FIELD_W'(c1_q);
  assign value_out_o     = FIELD_W'(val_q);
  assign operand_error_o = err_q;

endmodule

// File: rtl/emc_ctrl.sv
// Controller: sequences reductions, square-and-multiply steps and the final product.
module emc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  emc_pkg::emc_status_t sts_i,
  output emc_pkg::emc_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import emc_pkg::*;

  emc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (start_i) state_d = S_CHECK;
      S_CHECK:   state_d = sts_i.p_zero ? S_DONE : S_RED1_GO;
      S_RED1_GO: state_d = S_RED1;
      S_RED1:    if (sts_i.mul_done) state_d = S_RED2_GO;
      S_RED2_GO: state_d = S_RED2;
      S_RED2:    if (sts_i.mul_done) state_d = S_INIT;
      S_INIT:    state_d = S_SQ_GO;
      S_SQ_GO:   state_d = S_SQ;
      S_SQ: begin
        if (sts_i.mul_done) state_d = sts_i.exp_bit ? S_MUL_GO : S_NEXT;
      end
      S_MUL_GO:  state_d = S_MUL;
      S_MUL:     if (sts_i.mul_done) state_d = S_NEXT;
      S_NEXT:    state_d = sts_i.last_bit ? S_FIN_GO : S_SQ_GO;
      S_FIN_GO:  state_d = S_FIN;
      S_FIN:     if (sts_i.mul_done) state_d = S_DONE;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.load     = 1'b0;
    cmd_o.go       = 1'b0;
    cmd_o.exp_init = 1'b0;
    cmd_o.bit_next = 1'b0;
    cmd_o.mop      = MOP_NONE;
    done_o         = 1'b0;
    busy_o         = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      S_RED1_GO: begin
        cmd_o.go  = 1'b1;
        cmd_o.mop = MOP_RED1;
      end
      S_RED1:    cmd_o.mop = MOP_RED1;
      S_RED2_GO: begin
        cmd_o.go  = 1'b1;
        cmd_o.mop = MOP_RED2;
      end
      S_RED2:    cmd_o.mop = MOP_RED2;
      S_INIT:    cmd_o.exp_init = 1'b1;
      S_SQ_GO: begin
        cmd_o.go  = 1'b1;
        cmd_o.mop = MOP_SQ;
      end
      S_SQ:      cmd_o.mop = MOP_SQ;
      S_MUL_GO: begin
        cmd_o.go  = 1'b1;
        cmd_o.mop = MOP_MUL;
      end
      S_MUL:     cmd_o.mop = MOP_MUL;
      S_NEXT:    cmd_o.bit_next = !sts_i.last_bit;
      S_FIN_GO: begin
        cmd_o.go  = 1'b1;
        cmd_o.mop = MOP_FIN;
      end
      S_FIN:     cmd_o.mop = MOP_FIN;
      S_DONE:    done_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// File: rtl/emc_checker.sv
// Port-level checker for the cipher top level, with its bind.
module emc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // A result is only shown while the request is still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result strobe while not busy");

  // An accepted request keeps the block busy and gives no result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted request not held busy");

  // One strobe per request
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // Block returns to idle right after the result
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy)
    else $error("block still busy after result");

endmodule

bind elgamal_modexp_cipher emc_checker u_emc_checker (.*);
